// ===== rtl/gcb_pkg.sv =====
`timescale 1ns / 1ps

package gcb_pkg;

  // Vertex capacity of the adjacency store; masks are one bit per vertex.
  localparam int unsigned MaxVertices = 32;
  localparam int unsigned RowW        = MaxVertices;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = 6;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDone
  } state_e;

  typedef enum logic {
    ModeLoad  = 1'b0,
    ModeCheck = 1'b1
  } mode_e;

  typedef struct packed {
    logic            done;
    logic [RowW-1:0] reached;
  } walk_stat_t;

  // Mask of vertices in use: count 0 acts as 1, counts above capacity saturate.
  function automatic logic [RowW-1:0] used_mask(input logic [CntW-1:0] cnt);
    logic [RowW-1:0] m;
    m = '0;
    for (int i = 0; i < RowW; i++) begin
      m[i] = (CntW'(i) < cnt) || (i == 0);
    end
    return m;
  endfunction

  // Priority encoder, lowest set bit wins.
  function automatic logic [VtxW-1:0] lowest_set(input logic [RowW-1:0] m);
    logic [VtxW-1:0] k;
    k = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (m[i]) begin
        k = VtxW'(i);
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/gcb_in_if.sv =====
`timescale 1ns / 1ps

interface gcb_in_if;
  import gcb_pkg::*;

  logic            valid;
  logic            ready;
  logic            mode;
  logic [VtxW-1:0] row_index;
  logic [RowW-1:0] row_bits;

  modport source (output valid, output mode, output row_index, output row_bits,
                  input ready);
  modport sink   (input valid, input mode, input row_index, input row_bits,
                  output ready);
endinterface

// ===== rtl/gcb_out_if.sv =====
`timescale 1ns / 1ps

interface gcb_out_if;
  import gcb_pkg::*;

  logic            valid;
  logic            ready;
  logic            connected;
  logic [RowW-1:0] reached_mask;

  modport source (output valid, output connected, output reached_mask, input ready);
  modport sink   (input valid, input connected, input reached_mask, output ready);
endinterface

// ===== rtl/gcb_cfg_if.sv =====
`timescale 1ns / 1ps

interface gcb_cfg_if;
  import gcb_pkg::*;

  logic            valid;
  logic            ready;
  logic [CntW-1:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

// ===== rtl/gcb_ram.sv =====
`timescale 1ns / 1ps

module gcb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gcb_walk.sv =====
`timescale 1ns / 1ps

module gcb_walk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gcb_pkg::RowW-1:0]     all_mask_i,
  input  logic [gcb_pkg::RowW-1:0]     rd_data_i,
  output logic                         rd_en_o,
  output logic [gcb_pkg::VtxW-1:0]     rd_addr_o,
  output gcb_pkg::walk_stat_t          stat_o
);
  import gcb_pkg::*;

  logic            active_q, active_d;
  logic            pend_q, pend_d;
  logic [RowW-1:0] visited_q, visited_d;
  logic [RowW-1:0] frontier_q, frontier_d;

  logic [RowW-1:0] fresh;
  logic [RowW-1:0] front_cur;
  logic [VtxW-1:0] pick;
  logic [RowW-1:0] pick_oh;
  logic            done;

  // Row data from the previous pop merges in before the next pick; pops may
  // run ahead of merges since visiting order does not matter.
  always_comb begin
    fresh     = pend_q ? (rd_data_i & all_mask_i & ~visited_q) : '0;
    front_cur = frontier_q | fresh;
    pick      = lowest_set(front_cur);
    pick_oh   = RowW'(1) << pick;

    active_d   = active_q;
    pend_d     = 1'b0;
    visited_d  = visited_q;
    frontier_d = frontier_q;
    rd_en_o    = 1'b0;
    done       = 1'b0;

    if (start_i) begin
      active_d   = 1'b1;
      visited_d  = RowW'(1);
      frontier_d = RowW'(1);
    end else if (active_q) begin
      visited_d = visited_q | fresh;
      if (front_cur != '0) begin
        frontier_d = front_cur & ~pick_oh;
        pend_d     = 1'b1;
        rd_en_o    = 1'b1;
      end else begin
        active_d   = 1'b0;
        frontier_d = '0;
        done       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      pend_q     <= 1'b0;
      visited_q  <= '0;
      frontier_q <= '0;
    end else begin
      active_q   <= active_d;
      pend_q     <= pend_d;
      visited_q  <= visited_d;
      frontier_q <= frontier_d;
    end
  end

  assign rd_addr_o      = pick;
  assign stat_o.done    = done;
  assign stat_o.reached = visited_q;

endmodule

// ===== rtl/graph_connectivity_bfs.sv =====
`timescale 1ns / 1ps

// Connectivity check of an undirected graph held as an adjacency matrix.
// A load transaction (mode 0) writes one 32-bit row into the adjacency RAM,
// and loads stream back to back. A check transaction (mode 1) walks from
// vertex 0, lowest frontier vertex first, over the first vertex_count
// vertices and returns one result: connected, and the mask of reached
// vertices. The walk pops one frontier vertex per cycle and issues its row
// read to the single RAM read port, merging the returned row into the
// frontier in the following cycle. No new transaction is taken while a
// check runs. The result sits in an output register, so the next
// transaction is taken while a result still waits. vertex_count resets to
// 32; 0 acts as 1 and values above 32 saturate. Rows must be loaded before a
// check reads them; unwritten rows give undefined results.
module graph_connectivity_bfs (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcb_in_if.sink     in_i,
  gcb_cfg_if.sink    cfg_i,
  gcb_out_if.source  out_o
);
  import gcb_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0] vcnt_q;
  logic [RowW-1:0] all_mask;

  logic            in_acc;
  logic            ram_we;
  logic            walk_start;
  logic            rd_en;
  logic [VtxW-1:0] rd_addr;
  logic [RowW-1:0] rd_data;
  walk_stat_t      walk_stat;

  logic            out_free;
  logic            out_load;
  logic            out_valid_q, out_valid_d;
  logic            out_conn_q;
  logic [RowW-1:0] out_mask_q;

  // Config register; the user must write it only while idle (the block does not enforce this), so always ready.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= CntW'(MaxVertices);
    end else if (cfg_i.valid) begin
      vcnt_q <= cfg_i.vertex_count;
    end
  end

  assign all_mask = used_mask(vcnt_q);

  // Input side: loads go straight to the RAM, checks kick off the walk.
  assign in_acc     = in_i.valid && in_i.ready;
  assign ram_we     = in_acc && (in_i.mode == ModeLoad);
  assign walk_start = in_acc && (in_i.mode == ModeCheck);

  gcb_ram #(
    .Width (RowW),
    .Depth (MaxVertices)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.row_index),
    .wdata_i (in_i.row_bits),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  gcb_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .all_mask_i (all_mask),
    .rd_data_i  (rd_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .stat_o     (walk_stat)
  );

  // Output slot frees up in the same cycle it is taken.
  assign out_free = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (walk_start) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (walk_stat.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State outputs
  always_comb begin
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      StIdle:  in_i.ready = 1'b1;
      StWalk:  ;
      StDone:  out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; walk's visited set stays put until the next check.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_conn_q <= ((walk_stat.reached & all_mask) == all_mask);
      out_mask_q <= walk_stat.reached;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.connected    = out_conn_q;
  assign out_o.reached_mask = out_mask_q;

endmodule

// ===== bench/graph_connectivity_bfs_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the adjacency-matrix connectivity block.
// Stimulus runs row loads and connectivity checks through the input channel.
// It writes vertex_count between phases, once the block has gone idle.
// Every accepted transaction goes to a scoreboard. The scoreboard keeps its
// own copy of the adjacency rows and of the vertex count. On each check it
// walks the graph and queues the expected result.
module graph_connectivity_bfs_tb;
  import gcb_pkg::*;

  // One expected check outcome.
  typedef struct {
    logic            connected;
    logic [RowW-1:0] reached;
  } reach_t;

  // Mirrors the adjacency store and predicts each check in order of acceptance.
  class bfs_scoreboard;
    logic [RowW-1:0] adj_rows [MaxVertices];
    logic [CntW-1:0] vtx_count;
    reach_t          reach_q[$];
    int unsigned     mismatches;
    int unsigned     loads;
    int unsigned     checks;

    function new();
      vtx_count  = CntW'(MaxVertices);
      mismatches = 0;
      loads      = 0;
      checks     = 0;
      foreach (adj_rows[i]) adj_rows[i] = '0;
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endfunction

    // Called on every accepted input transaction.
    function void note_item(mode_e mode, logic [VtxW-1:0] idx, logic [RowW-1:0] bits);
      int unsigned     n;
      int              cur;
      logic [RowW-1:0] in_use;
      logic [RowW-1:0] seen;
      logic [RowW-1:0] front;
      logic [RowW-1:0] fresh;
      reach_t          r;
      if (mode == ModeLoad) begin
        adj_rows[idx] = bits;
        loads++;
        return;
      end
      // Count 0 means a single vertex; anything past capacity saturates.
      n = (vtx_count == 0) ? 1 : (vtx_count > MaxVertices) ? MaxVertices : vtx_count;
      in_use = (n >= RowW) ? '1 : ((RowW'(1) << n) - 1'b1);
      seen  = RowW'(1);
      front = RowW'(1);
      // Frontier set instead of a queue: pop the lowest vertex, merge its
      // unseen neighbors inside the used range.
      for (int g = 0; g < n && front != '0; g++) begin
        cur = -1;
        for (int k = 0; k < RowW && cur < 0; k++) begin
          if (front[k]) cur = k;
        end
        front[cur] = 1'b0;
        fresh = adj_rows[cur] & in_use & ~seen;
        seen  |= fresh;
        front |= fresh;
      end
      r.connected = ((seen & in_use) == in_use);
      r.reached   = seen;
      reach_q.push_back(r);
      checks++;
    endfunction

    // Called on every accepted result transaction.
    function void check_result(logic conn, logic [RowW-1:0] mask);
      reach_t want;
      if (reach_q.size() == 0) begin
        report($sformatf("unexpected result connected=%0b mask=%h", conn, mask));
        return;
      end
      want = reach_q.pop_front();
      if (conn !== want.connected) begin
        report($sformatf("connected=%0b, expected %0b (mask %h)",
                         conn, want.connected, want.reached));
      end
      if (mask !== want.reached) begin
        report($sformatf("reached_mask=%h, expected %h", mask, want.reached));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gcb_in_if  in_if ();
  gcb_cfg_if cfg_if ();
  gcb_out_if out_if ();

  graph_connectivity_bfs dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  bfs_scoreboard          sb;
  logic [MaxVertices-1:0] rows_loaded;    // rows the walk may safely read
  int unsigned            items_sent;
  int unsigned            settings_used;
  bit                     quiet;          // no random gaps either side; holds remain

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("[%0t] timeout: run did not complete", $time);
    $display("status: fail");
    $finish;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Row contents from empty through sparse to full.
  function automatic logic [RowW-1:0] random_row(int unsigned style);
    case (style)
      0:       return '0;
      1:       return RowW'(1) << $urandom_range(0, RowW - 1);
      2:       return $urandom & $urandom & $urandom;
      3:       return $urandom & $urandom;
      4:       return $urandom;
      default: return '1;
    endcase
  endfunction

  // One input transaction. Inputs change at the falling edge. Valid stays up
  // across back-to-back transactions. Ready is sampled at the rising edge.
  task automatic push_item(mode_e mode, logic [VtxW-1:0] idx, logic [RowW-1:0] bits);
    int unsigned gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.mode      = mode;
    in_if.row_index = idx;
    in_if.row_bits  = bits;
    do @(posedge clk); while (!in_if.ready);
    sb.note_item(mode, idx, bits);
    items_sent++;
    if (mode == ModeLoad) rows_loaded[idx] = 1'b1;
  endtask

  // Register write, only once the block is idle. Loads give no result, so a
  // settle time follows the drain.
  task automatic set_vertex_count(logic [CntW-1:0] count);
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.reach_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_if.valid        = 1'b1;
    cfg_if.vertex_count = count;
    do @(posedge clk); while (!cfg_if.ready);
    sb.vtx_count = count;
    settings_used++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Load rows 0..rows-1 of an n-vertex graph. Path graphs give the deepest
  // walk, and a random cut may split them. The noisy variant also sets bits
  // above the count, which the walk must ignore.
  task automatic load_graph(int unsigned n, int unsigned rows);
    int unsigned     style;
    int unsigned     cut;
    logic [RowW-1:0] row;
    style = $urandom_range(0, 7);
    cut   = $urandom_range(0, 2 * n);
    for (int i = 0; i < rows; i++) begin
      if (style >= 6) begin
        row = '0;
        if (i + 1 < n && i != cut) row[i+1] = 1'b1;
        if (i > 0 && i - 1 != cut) row[i-1] = 1'b1;
        if (style == 7) row |= $urandom & $urandom & ~((RowW'(1) << n) - 1'b1);
      end else begin
        row = random_row(style);
      end
      push_item(ModeLoad, VtxW'(i), row);
    end
  endtask

  // Every row a check may read has to be loaded first.
  task automatic ensure_rows(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (!rows_loaded[i]) push_item(ModeLoad, VtxW'(i), random_row($urandom_range(0, 5)));
    end
  endtask

  // Result side: random stalls, plus long holds while the sender keeps going,
  // so the result register fills and the block backs up its input.
  initial begin : result_sink
    int unsigned stall;
    int unsigned held;
    int unsigned next_hold;
    out_if.ready = 1'b0;
    stall        = 0;
    next_hold    = 300;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (items_sent >= next_hold) begin
        out_if.ready = 1'b0;
        for (held = 0; held < 400; held++) @(negedge clk);
        next_hold += 600;
      end
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else begin
        out_if.ready = 1'b1;
        stall = idle_len();
      end
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.connected, out_if.reached_mask);
      end
    end
  end

  initial begin : stimulus
    logic [CntW-1:0] count;
    int unsigned     n_used;
    int unsigned     phase_end;
    int unsigned     act;
    int unsigned     p;
    sb                  = new();
    rows_loaded         = '0;
    items_sent          = 0;
    settings_used       = 0;
    quiet               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.mode          = ModeLoad;
    in_if.row_index     = '0;
    in_if.row_bits      = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.vertex_count = '0;
    rst_n               = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: a single vertex, with bits past the count set in its row.
    set_vertex_count(1);
    push_item(ModeLoad, 0, '1);
    push_item(ModeCheck, 0, '0);
    // A count of zero acts as one. A check ignores its row fields.
    set_vertex_count(0);
    push_item(ModeCheck, 31, '1);
    // Two vertices: no edge, then an edge stored in one direction only.
    set_vertex_count(2);
    push_item(ModeLoad, 1, '0);
    push_item(ModeLoad, 0, '0);
    push_item(ModeCheck, 0, '0);
    push_item(ModeLoad, 0, 32'h2);
    push_item(ModeCheck, 0, '0);
    // The edge appears only in row 1, so the walk from vertex 0 cannot reach it.
    push_item(ModeLoad, 0, '0);
    push_item(ModeLoad, 1, 32'h1);
    push_item(ModeCheck, 0, '0);
    // Full rows, including the top row index. Two checks back to back.
    push_item(ModeLoad, 31, '1);
    push_item(ModeLoad, 0, '1);
    push_item(ModeCheck, 0, '0);
    push_item(ModeCheck, 31, '1);
    // A three-vertex path, loaded from the far end.
    set_vertex_count(3);
    push_item(ModeLoad, 2, 32'h2);
    push_item(ModeLoad, 1, 32'h4);
    push_item(ModeLoad, 0, 32'h2);
    push_item(ModeCheck, 0, '0);

    // Random phases. The first three cover the large counts. After that,
    // most counts are small, and the extremes come back now and then.
    p = 0;
    while (items_sent < 1090) begin
      if (p < 3) begin
        count = (p == 0) ? CntW'(32) : (p == 1) ? CntW'(63) : CntW'(33);
      end else begin
        act = $urandom_range(0, 99);
        if (act < 10) begin
          case ($urandom_range(0, 4))
            0:       count = CntW'(0);
            1:       count = CntW'(1);
            2:       count = CntW'(32);
            3:       count = CntW'(33);
            default: count = CntW'(63);
          endcase
        end else if (act < 70) begin
          count = CntW'($urandom_range(2, 8));
        end else begin
          count = CntW'($urandom_range(9, 31));
        end
      end
      p++;
      set_vertex_count(count);
      n_used    = (count == 0) ? 1 : (count > MaxVertices) ? MaxVertices : count;
      quiet     = ($urandom_range(0, 4) == 0);
      phase_end = items_sent + $urandom_range(60, 160);
      while (items_sent < phase_end) begin
        act = $urandom_range(0, 99);
        if (act < 40) begin
          load_graph(n_used, n_used);
        end else if (act < 62) begin
          repeat ($urandom_range(1, 3)) begin
            push_item(ModeLoad, VtxW'($urandom_range(0, 31)),
                      random_row($urandom_range(0, 5)));
          end
        end else if (act < 72) begin
          load_graph(n_used, $urandom_range(1, n_used));
        end else if (act < 86) begin
          // Loads only, no check after them.
          repeat ($urandom_range(1, 4)) begin
            push_item(ModeLoad, VtxW'($urandom_range(0, 31)), $urandom);
          end
        end
        if (act < 72 || act >= 86) begin
          ensure_rows(n_used);
          push_item(ModeCheck, VtxW'($urandom_range(0, 31)), $urandom);
        end
      end
    end

    // Drain, then allow for a late or extra result.
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.reach_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d row loads and %0d connectivity checks over %0d vertex-count settings",
             sb.loads, sb.checks, settings_used);
    $display("mismatches seen: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gcb_pkg.sv
rtl/gcb_in_if.sv
rtl/gcb_out_if.sv
rtl/gcb_cfg_if.sv
rtl/gcb_ram.sv
rtl/gcb_walk.sv
rtl/graph_connectivity_bfs.sv
bench/graph_connectivity_bfs_tb.sv
